// ===== sv/sha256_byte_stream_hasher_top_assert.svh =====
// assertion macros for the sha256 byte stream hasher top level
// depends on nothing; included inside the top level module body
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
// assert that a condition implies another on the same edge
`define SHB_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
// assert that a condition implies another on the next edge
`define SHB_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`endif

// ===== sv/shb_pkg.sv =====
// shared types, constants and functions of the sha256 byte stream hasher
// depends on nothing
package shb_pkg;
	localparam int WORDS = 8;
	localparam int ROUNDS = 64;
	localparam int BLOCK_BYTES = 64;
	localparam int LENGTH_POS = 56;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// controller to datapath commands
	typedef struct packed {
		logic load_byte;   // write byte at fill point
		logic pad_byte;    // write pad byte at fill point
		logic start_blk;   // capture chaining value into working vars
		logic round;       // run one round
		logic finish_blk;  // add working vars into chaining value
		logic reset_msg;   // back to initial hash, clear length
	} shb_cmd_t;

	typedef logic [31:0] word_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t k_const(input logic [5:0] i);
		word_t k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		k_const = k[i];
	endfunction

	function automatic word_t h_init(input logic [2:0] i);
		word_t h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		h_init = h[i];
	endfunction
endpackage

// ===== sv/shb_ctrl.sv =====
// controller state machine of the sha256 byte stream hasher
// depends on shb_pkg
module shb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              has_byte,
	input  logic              end_of_message,
	input  logic [6:0]        fill,
	output shb_pkg::shb_cmd_t cmd,
	output logic [5:0]        round_idx,
	output logic              pad_sel,   // datapath writes pad/zero/length at fill
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        word_index,
	output logic              busy
);
	import shb_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_FIN   = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_CLEAR = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [5:0] round_q;
	logic [2:0] word_q;
	logic final_q;   // padding in progress
	logic eom_q;     // end_of_message as seen on the last accepted beat
	logic extra_q;   // mark landed past the length slot, length goes in one more block

	assign round_idx = round_q;
	assign word_index = word_q;
	assign out_valid = (state_q == ST_EMIT);
	assign in_stall = (state_q != ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign pad_sel = (state_q == ST_PAD);

	logic acc;
	assign acc = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd.load_byte = has_byte;
					if (has_byte && fill == 7'(BLOCK_BYTES - 1))
						state_d = ST_START;
					else if (end_of_message)
						state_d = ST_PAD;
				end
			end
			ST_START: begin
				cmd.start_blk = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (round_q == 6'(ROUNDS - 1))
					state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish_blk = 1'b1;
				if (final_q && !extra_q)
					state_d = ST_EMIT;
				else if (final_q || eom_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_PAD: begin
				// one byte per cycle up to the block end
				cmd.pad_byte = 1'b1;
				if (fill == 7'(BLOCK_BYTES - 1))
					state_d = ST_START;
			end
			ST_EMIT: begin
				if (!out_stall && word_q == 3'(WORDS - 1))
					state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				cmd.reset_msg = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			word_q <= '0;
			final_q <= 1'b0;
			eom_q <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.round) round_q <= round_q + 6'd1;
			else if (cmd.start_blk) round_q <= '0;
			if (state_q == ST_EMIT && !out_stall) word_q <= word_q + 3'd1;
			if (acc) eom_q <= end_of_message;
			if (state_q == ST_PAD && !final_q) extra_q <= (fill >= 7'(LENGTH_POS));
			if (cmd.finish_blk) extra_q <= 1'b0;
			if (state_q == ST_PAD) final_q <= 1'b1;
			if (cmd.reset_msg) begin
				final_q <= 1'b0;
				eom_q <= 1'b0;
			end
		end
	end
endmodule

// ===== sv/shb_datapath.sv =====
// datapath: block buffer, schedule, round unit, chaining value, length
// depends on shb_pkg
module shb_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  shb_pkg::shb_cmd_t cmd,
	input  logic [5:0]        round_idx,
	input  logic [7:0]        data_byte,
	input  logic              pad_first,  // high while padding; the first pad byte is the mark
	input  logic [2:0]        word_index,
	output logic [6:0]        fill,
	output logic [31:0]       digest_word
);
	import shb_pkg::*;

	// block buffer as sixteen big-endian words, one byte lane written per beat
	logic [31:0] blk_q [16];
	logic [31:0] w_q [16];
	logic [31:0] h_q [WORDS];
	logic [31:0] v_q [WORDS];
	logic [6:0]  fill_q;
	logic [63:0] len_q;
	logic        mark_q;   // pad mark already written

	assign fill = fill_q;
	assign digest_word = h_q[word_index];

	logic [63:0] bits;
	logic [7:0]  pad_val;
	logic [5:0]  lpos;
	logic [4:0]  lane;
	assign bits = {len_q[60:0], 3'b000};
	assign lpos = fill_q[5:0];
	assign lane = {~lpos[1:0], 3'b000};

	always_comb begin
		if (!mark_q && pad_first)
			pad_val = PAD_MARK;
		else if (fill_q >= 7'(LENGTH_POS) && mark_q)
			pad_val = bits[{~lpos[2:0], 3'b000} +: 8];
		else
			pad_val = 8'h00;
	end

	// the mark goes first; length only if mark already in an earlier slot
	logic len_ok_q;

	logic [31:0] s0, s1, wnew, t1, t2, e, a;
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = w_q[0] + s0 + w_q[9] + s1;
	assign e = v_q[4];
	assign a = v_q[0];
	assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + k_const(round_idx) + w_q[0];
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.load_byte) blk_q[lpos[5:2]][lane +: 8] <= data_byte;
		if (cmd.pad_byte) begin
			if (!mark_q || fill_q < 7'(LENGTH_POS) || !len_ok_q)
				blk_q[lpos[5:2]][lane +: 8] <= (!mark_q) ? PAD_MARK : 8'h00;
			else
				blk_q[lpos[5:2]][lane +: 8] <= pad_val;
		end
		if (cmd.start_blk)
			for (int i = 0; i < 16; i++)
				w_q[i] <= blk_q[i];
		else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
		if (cmd.start_blk)
			for (int i = 0; i < WORDS; i++) v_q[i] <= h_q[i];
		else if (cmd.round) begin
			for (int i = 1; i < WORDS; i++) v_q[i] <= v_q[i-1];
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q <= '0;
			mark_q <= 1'b0;
			len_ok_q <= 1'b0;
			for (int i = 0; i < WORDS; i++) h_q[i] <= h_init(3'(i));
		end else begin
			if (cmd.load_byte) begin
				fill_q <= fill_q + 7'd1;
				len_q <= len_q + 64'd1;
			end
			if (cmd.pad_byte) begin
				fill_q <= fill_q + 7'd1;
				if (!mark_q) begin
					mark_q <= 1'b1;
					len_ok_q <= (fill_q < 7'(LENGTH_POS));
				end
			end
			if (cmd.finish_blk) begin
				for (int i = 0; i < WORDS; i++) h_q[i] <= h_q[i] + v_q[i];
				// last block holds the length: keep fill at 64 as a marker
				if (!(mark_q && len_ok_q)) fill_q <= '0;
				if (mark_q) len_ok_q <= 1'b1;
			end
			if (cmd.reset_msg) begin
				fill_q <= '0;
				len_q <= '0;
				mark_q <= 1'b0;
				len_ok_q <= 1'b0;
				for (int i = 0; i < WORDS; i++) h_q[i] <= h_init(3'(i));
			end
		end
	end
endmodule

// ===== sv/sha256_byte_stream_hasher_top.sv =====
// top level of the sha256 byte stream hasher
// depends on shb_pkg, shb_ctrl, shb_datapath and the assertion header
//
// channel  direction  fields                                   handshake
// in       input      data_byte, has_byte, end_of_message      in_valid / in_stall
// out      output     digest_word, word_index, last_word       out_valid / out_stall
//
// a byte that does not fill a block is just written to the buffer; a full block adds a load,
// 64 rounds on the one round unit and an add-back
// end of message: pad bytes up to the block end and one or two compressions, then
// the eight digest words and a clear step; arst_n returns the initial hash and zero length
// out_stall holds the current digest word; input is stalled while busy
module sha256_byte_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shb_pkg::*;

	shb_cmd_t   cmd;
	logic [5:0] round_idx;
	logic [6:0] fill;
	logic       pad_sel;
	logic       busy;

	shb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.has_byte(has_byte), .end_of_message(end_of_message), .fill(fill),
		.cmd(cmd), .round_idx(round_idx), .pad_sel(pad_sel),
		.out_valid(out_valid), .out_stall(out_stall), .word_index(word_index),
		.busy(busy)
	);

	shb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .round_idx(round_idx),
		.data_byte(data_byte), .pad_first(pad_sel), .word_index(word_index),
		.fill(fill), .digest_word(digest_word)
	);

	assign last_word = (word_index == 3'(WORDS - 1));

	`include "sha256_byte_stream_hasher_top_assert.svh"

	`SHB_ASSERT_IMP(a_no_accept_busy, busy, in_stall)
	`SHB_ASSERT_IMP(a_out_not_idle, out_valid, busy)
	`SHB_ASSERT_NEXT(a_last_then_clear, out_valid && !out_stall && last_word, !out_valid)
endmodule
